// File: hw/rtl/gvdt_pkg.sv
`default_nettype none

package gvdt_pkg;

  // field widths
  localparam int unsigned O2W   = 14;
  localparam int unsigned CO2W  = 18;
  localparam int unsigned PRESW = 20;
  localparam int unsigned AIRTW = 16;
  localparam int unsigned GAINW = 16;
  localparam int unsigned TMRW  = 24;
  localparam int unsigned PRODW = CO2W + GAINW;

  // config port
  localparam int unsigned CFG_IDXW  = 3;
  localparam int unsigned CFG_DATAW = 20;

  localparam logic [CFG_IDXW-1:0] REG_CHAMBER_ENABLE   = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_O2_REFERENCE     = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_CO2_REFERENCE    = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_O2_SMALL_ERROR   = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_CO2_SMALL_ERROR  = 3'd4;
  localparam logic [CFG_IDXW-1:0] REG_PRESSURE_MIN     = 3'd5;
  localparam logic [CFG_IDXW-1:0] REG_AIR_OPEN_TIME_MS = 3'd6;

  // register reset values
  localparam logic [O2W-1:0]   RST_O2_REFERENCE     = 14'd2100;
  localparam logic [CO2W-1:0]  RST_CO2_REFERENCE    = 18'd50000;
  localparam logic [O2W-1:0]   RST_O2_SMALL_ERROR   = 14'd100;
  localparam logic [CO2W-1:0]  RST_CO2_SMALL_ERROR  = 18'd5000;
  localparam logic [PRESW-1:0] RST_PRESSURE_MIN     = 20'd100000;
  localparam logic [AIRTW-1:0] RST_AIR_OPEN_TIME_MS = 16'd1000;

  // default gains: dose gains Q8.8 ms per unit, air gains ms per unit of relative excess
  localparam logic [GAINW-1:0] DEF_O2_GAIN_LARGE  = 16'd2560;
  localparam logic [GAINW-1:0] DEF_O2_GAIN_SMALL  = 16'd1280;
  localparam logic [GAINW-1:0] DEF_CO2_GAIN_LARGE = 16'd64;
  localparam logic [GAINW-1:0] DEF_CO2_GAIN_SMALL = 16'd32;
  localparam logic [GAINW-1:0] DEF_AIR_GAIN_O2    = 16'd10000;
  localparam logic [GAINW-1:0] DEF_AIR_GAIN_CO2   = 16'd10000;

  typedef struct packed {
    logic             action;
    logic [O2W-1:0]   o2_level;
    logic [CO2W-1:0]  co2_level;
    logic [PRESW-1:0] chamber_pressure;
    logic             co2_sensor_ok;
  } in_t;

  typedef struct packed {
    logic o2_valve_open;
    logic co2_valve_open;
    logic air_valve_open;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, clear candidate times
    logic tick;      // count timers down
    logic gas;       // 0 O2, 1 CO2
    logic mul;       // register deficit/excess times gain
    logic dose;      // store dose time for selected gas
    logic div_init;  // load divider
    logic div_step;  // one quotient bit
    logic div_done;  // fold quotient into air time
    logic pres;      // fold low-pressure air time
    logic commit;    // candidate times -> timers
    logic out_load;  // capture valve flags
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic action;
    logic enable;
    logic above;
    logic below;
    logic div_last;
  } status_t;

  function automatic logic [TMRW-1:0] sat24(input logic [PRODW-1:0] v);
    logic [TMRW-1:0] r;
    r = (|v[PRODW-1:TMRW]) ? {TMRW{1'b1}} : v[TMRW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gvdt_ctrl.sv
`default_nettype none

module gvdt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire gvdt_pkg::status_t status,
  output gvdt_pkg::cmd_t        cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_EVAL   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_DIVEND = 4'd5;
  localparam logic [3:0] S_PRES   = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0] state, state_next;
  logic       gas, gas_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    gas_next       = gas;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.gas        = gas;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.action) begin
          cmd.tick   = 1'b1;
          state_next = S_RESULT;
        end else if (!status.enable) begin
          state_next = S_RESULT;
        end else begin
          gas_next   = 1'b0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (status.above) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.dose = status.below;
          gas_next = 1'b1;
          state_next = gas ? S_PRES : S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIVEND;
        end
      end
      S_DIVEND: begin
        cmd.div_done = 1'b1;
        gas_next     = 1'b1;
        state_next   = gas ? S_PRES : S_MUL;
      end
      S_PRES: begin
        cmd.pres   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gas       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gas       <= gas_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gvdt_dp.sv
`default_nettype none

module gvdt_dp #(
  parameter logic [gvdt_pkg::GAINW-1:0] O2_GAIN_LARGE  = gvdt_pkg::DEF_O2_GAIN_LARGE,
  parameter logic [gvdt_pkg::GAINW-1:0] O2_GAIN_SMALL  = gvdt_pkg::DEF_O2_GAIN_SMALL,
  parameter logic [gvdt_pkg::GAINW-1:0] CO2_GAIN_LARGE = gvdt_pkg::DEF_CO2_GAIN_LARGE,
  parameter logic [gvdt_pkg::GAINW-1:0] CO2_GAIN_SMALL = gvdt_pkg::DEF_CO2_GAIN_SMALL,
  parameter logic [gvdt_pkg::GAINW-1:0] AIR_GAIN_O2    = gvdt_pkg::DEF_AIR_GAIN_O2,
  parameter logic [gvdt_pkg::GAINW-1:0] AIR_GAIN_CO2   = gvdt_pkg::DEF_AIR_GAIN_CO2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gvdt_pkg::CFG_IDXW-1:0]  cfg_index,
  input  wire logic [gvdt_pkg::CFG_DATAW-1:0] cfg_data,
  input  wire gvdt_pkg::in_t                  in_data,
  input  wire gvdt_pkg::cmd_t                 cmd,
  output gvdt_pkg::status_t                   status,
  output gvdt_pkg::out_t                      out_data
);

  localparam int unsigned O2W   = gvdt_pkg::O2W;
  localparam int unsigned CO2W  = gvdt_pkg::CO2W;
  localparam int unsigned PRESW = gvdt_pkg::PRESW;
  localparam int unsigned AIRTW = gvdt_pkg::AIRTW;
  localparam int unsigned GAINW = gvdt_pkg::GAINW;
  localparam int unsigned TMRW  = gvdt_pkg::TMRW;
  localparam int unsigned PRODW = gvdt_pkg::PRODW;
  localparam int unsigned CNTW  = $clog2(PRODW);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(PRODW - 1);

  // config registers
  logic             chamber_enable;
  logic [O2W-1:0]   o2_reference;
  logic [CO2W-1:0]  co2_reference;
  logic [O2W-1:0]   o2_small_error;
  logic [CO2W-1:0]  co2_small_error;
  logic [PRESW-1:0] pressure_min;
  logic [AIRTW-1:0] air_open_time_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      chamber_enable   <= 1'b0;
      o2_reference     <= gvdt_pkg::RST_O2_REFERENCE;
      co2_reference    <= gvdt_pkg::RST_CO2_REFERENCE;
      o2_small_error   <= gvdt_pkg::RST_O2_SMALL_ERROR;
      co2_small_error  <= gvdt_pkg::RST_CO2_SMALL_ERROR;
      pressure_min     <= gvdt_pkg::RST_PRESSURE_MIN;
      air_open_time_ms <= gvdt_pkg::RST_AIR_OPEN_TIME_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gvdt_pkg::REG_CHAMBER_ENABLE:   chamber_enable   <= cfg_data[0];
        gvdt_pkg::REG_O2_REFERENCE:     o2_reference     <= cfg_data[O2W-1:0];
        gvdt_pkg::REG_CO2_REFERENCE:    co2_reference    <= cfg_data[CO2W-1:0];
        gvdt_pkg::REG_O2_SMALL_ERROR:   o2_small_error   <= cfg_data[O2W-1:0];
        gvdt_pkg::REG_CO2_SMALL_ERROR:  co2_small_error  <= cfg_data[CO2W-1:0];
        gvdt_pkg::REG_PRESSURE_MIN:     pressure_min     <= cfg_data[PRESW-1:0];
        gvdt_pkg::REG_AIR_OPEN_TIME_MS: air_open_time_ms <= cfg_data[AIRTW-1:0];
        default: ;
      endcase
    end
  end

  // captured input word
  gvdt_pkg::in_t word;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= in_data;
    end
  end

  // selected gas
  logic [CO2W-1:0]  level, ref_lvl, small_err, diff;
  logic [GAINW-1:0] gain;
  logic             above, below;

  always_comb begin
    level     = cmd.gas ? word.co2_level : CO2W'(word.o2_level);
    ref_lvl   = cmd.gas ? co2_reference : CO2W'(o2_reference);
    small_err = cmd.gas ? co2_small_error : CO2W'(o2_small_error);
    above     = level > ref_lvl;
    below     = level < ref_lvl;
    diff      = above ? (level - ref_lvl) : (ref_lvl - level);
    if (above) begin
      gain = cmd.gas ? AIR_GAIN_CO2 : AIR_GAIN_O2;
    end else if (diff < small_err) begin
      gain = cmd.gas ? CO2_GAIN_SMALL : O2_GAIN_SMALL;
    end else begin
      gain = cmd.gas ? CO2_GAIN_LARGE : O2_GAIN_LARGE;
    end
  end

  logic [PRODW-1:0] prod;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PRODW'(diff) * PRODW'(gain);
    end
  end

  // restoring divider, one quotient bit per cycle; divisor is the level (>= 1 when above)
  logic [PRODW-1:0] quo;
  logic [CO2W-1:0]  rem;
  logic [CNTW-1:0]  cnt;
  logic [CO2W:0]    shifted, trial;

  assign shifted = {rem, quo[PRODW-1]};
  assign trial   = shifted - {1'b0, level};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo <= prod;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNTW'(1);
      if (!trial[CO2W]) begin
        rem <= trial[CO2W-1:0];
        quo <= {quo[PRODW-2:0], 1'b1};
      end else begin
        rem <= shifted[CO2W-1:0];
        quo <= {quo[PRODW-2:0], 1'b0};
      end
    end
  end

  // candidate times and timers
  logic [TMRW-1:0] new_o2, new_co2, new_air;
  logic [TMRW-1:0] o2_time_left, co2_time_left, air_time_left;
  logic [TMRW-1:0] dose_t, div_t, pres_t;

  assign dose_t = gvdt_pkg::sat24(PRODW'(prod[PRODW-1:8]));
  assign div_t  = gvdt_pkg::sat24(quo);
  assign pres_t = TMRW'(air_open_time_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      o2_time_left  <= '0;
      co2_time_left <= '0;
      air_time_left <= '0;
    end else if (cmd.tick) begin
      o2_time_left  <= (o2_time_left != '0) ? o2_time_left - TMRW'(1) : '0;
      co2_time_left <= (co2_time_left != '0) ? co2_time_left - TMRW'(1) : '0;
      air_time_left <= (air_time_left != '0) ? air_time_left - TMRW'(1) : '0;
    end else if (cmd.commit) begin
      o2_time_left  <= new_o2;
      co2_time_left <= new_co2;
      air_time_left <= new_air;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_o2  <= '0;
      new_co2 <= '0;
      new_air <= '0;
    end else if (cmd.dose) begin
      if (cmd.gas) begin
        new_co2 <= dose_t;
      end else begin
        new_o2 <= dose_t;
      end
    end else if (cmd.div_done) begin
      if (div_t > new_air) begin
        new_air <= div_t;
      end
    end else if (cmd.pres) begin
      if ((word.chamber_pressure < pressure_min) && (pres_t > new_air)) begin
        new_air <= pres_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.o2_valve_open  <= chamber_enable && (o2_time_left != '0);
      out_data.co2_valve_open <= chamber_enable && (co2_time_left != '0) && word.co2_sensor_ok;
      out_data.air_valve_open <= chamber_enable && (air_time_left != '0);
    end
  end

  assign status.action   = word.action;
  assign status.enable   = chamber_enable;
  assign status.above    = above;
  assign status.below    = below;
  assign status.div_last = (cnt == CNT_LAST);

endmodule

`default_nettype wire

// File: hw/rtl/gas_valve_dosing_timer_top.sv
`default_nettype none

// Gas valve dosing timer. Each input word is either a 1 ms tick (action 0) or a
// measurement set (action 1); every word yields exactly one output word with the
// O2, CO2 and air valve flags after that word's update. A tick, or a measurement
// while the chamber is disabled, passes through accept, decode and result. A
// measurement with the chamber enabled runs a multiply and an evaluate step
// per gas, plus a division when the gas is above reference (the
// relative-excess division runs through a shared restoring divider at one
// quotient bit per cycle, 34 bits), then the pressure check, commit and result.
// The divider sets the worst case. One word is in work at a time; the output
// register lets the block take the next input while a result waits on stall.
// Config writes (cfg_we/cfg_index/cfg_data) belong in idle periods only.
module gas_valve_dosing_timer_top #(
  parameter logic [gvdt_pkg::GAINW-1:0] O2_GAIN_LARGE  = gvdt_pkg::DEF_O2_GAIN_LARGE,
  parameter logic [gvdt_pkg::GAINW-1:0] O2_GAIN_SMALL  = gvdt_pkg::DEF_O2_GAIN_SMALL,
  parameter logic [gvdt_pkg::GAINW-1:0] CO2_GAIN_LARGE = gvdt_pkg::DEF_CO2_GAIN_LARGE,
  parameter logic [gvdt_pkg::GAINW-1:0] CO2_GAIN_SMALL = gvdt_pkg::DEF_CO2_GAIN_SMALL,
  parameter logic [gvdt_pkg::GAINW-1:0] AIR_GAIN_O2    = gvdt_pkg::DEF_AIR_GAIN_O2,
  parameter logic [gvdt_pkg::GAINW-1:0] AIR_GAIN_CO2   = gvdt_pkg::DEF_AIR_GAIN_CO2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [gvdt_pkg::CFG_IDXW-1:0]  cfg_index,
  input  wire logic [gvdt_pkg::CFG_DATAW-1:0] cfg_data,
  // input words
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire gvdt_pkg::in_t                  in_data,
  // output words
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output gvdt_pkg::out_t                      out_data
);

  gvdt_pkg::cmd_t    cmd;
  gvdt_pkg::status_t status;

  // sequencer: accept, decode, per-gas multiply / divide steps, pressure, commit, output
  gvdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // config registers, timers, multiplier, divider, output flags
  gvdt_dp #(
    .O2_GAIN_LARGE  (O2_GAIN_LARGE),
    .O2_GAIN_SMALL  (O2_GAIN_SMALL),
    .CO2_GAIN_LARGE (CO2_GAIN_LARGE),
    .CO2_GAIN_SMALL (CO2_GAIN_SMALL),
    .AIR_GAIN_O2    (AIR_GAIN_O2),
    .AIR_GAIN_CO2   (AIR_GAIN_CO2)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
